// ===== hdl/ghp_pkg.sv =====
// Shared types and constants for the generational handle pool.
`timescale 1ns / 1ps

package ghp_pkg;

   localparam int GEN_W     = 16;
   localparam int IDX_OUT_W = 8;
   localparam int CNT_OUT_W = 9;

   localparam logic [GEN_W-1:0] GEN_FIRST = 16'd1;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CHECK = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [IDX_OUT_W-1:0] slot_index;
      logic [GEN_W-1:0]     slot_generation;
   } req_payload_type;

   typedef struct packed {
      logic                 ok;
      logic [IDX_OUT_W-1:0] out_index;
      logic [GEN_W-1:0]     out_generation;
      logic [CNT_OUT_W-1:0] live_count;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic pop;
      logic finish;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic want_pop;
   } sts_type;

endpackage

// ===== hdl/ghp_if.sv =====
// Request and response channel interfaces for the generational handle pool.
`timescale 1ns / 1ps

interface ghp_req_if import ghp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ghp_rsp_if import ghp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ghp_dp.sv =====
// Datapath: generation table, free stack, counters and response register.
`timescale 1ns / 1ps

module ghp_dp import ghp_pkg::*; #(
   parameter int SLOTS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  ctl_type         ctl,
   output sts_type         sts,
   input  req_payload_type req,
   output rsp_payload_type rsp
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int WIDE_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
   localparam int ENT_W  = GEN_W + 1;

   // table entry: in-use mark above the generation
   logic [ENT_W-1:0] gen_mem [SLOTS];
   logic [IDX_W-1:0] stk_mem [SLOTS];

   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] used_ff, used_in;

   logic [1:0]       cmd_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [GEN_W-1:0] gen_ff;
   logic             in_range_ff, in_range_in;
   logic             popped_ff;

   logic [ENT_W-1:0] gen_rd_ff;
   logic [IDX_W-1:0] stk_rd_ff;

   rsp_payload_type  rsp_ff, rsp_in;

   logic             gen_rd_en, stk_rd_en, gen_wr_en, stk_wr_en;
   logic [IDX_W-1:0] gen_rd_addr, stk_rd_addr, gen_wr_addr, stk_wr_addr;
   logic [ENT_W-1:0] gen_wr_data;

   logic             is_lookup, live, pool_full;

   assign in_range_in = WIDE_W'(req.slot_index) < WIDE_W'(hw_ff);
   assign is_lookup   = (req.cmd == CMD_FREE) || (req.cmd == CMD_CHECK);
   assign sts.want_pop = (req.cmd == CMD_ALLOC) && (depth_ff != '0);

   assign live = in_range_ff && gen_rd_ff[GEN_W] && (gen_rd_ff[GEN_W-1:0] == gen_ff);
   assign pool_full = (hw_ff == CNT_W'(SLOTS));

   // read ports: stack on accept of a reusing allocate, table on lookup or after pop
   always_comb begin
      stk_rd_en   = ctl.accept && sts.want_pop;
      stk_rd_addr = IDX_W'(depth_ff - 1'b1);
      gen_rd_en   = (ctl.accept && is_lookup && in_range_in) || ctl.pop;
      gen_rd_addr = ctl.pop ? stk_rd_ff : IDX_W'(req.slot_index);
      idx_in      = ctl.pop ? stk_rd_ff : IDX_W'(req.slot_index);
   end

   always_comb begin
      depth_in    = depth_ff;
      hw_in       = hw_ff;
      used_in     = used_ff;
      gen_wr_en   = 1'b0;
      gen_wr_addr = idx_ff;
      gen_wr_data = '0;
      stk_wr_en   = 1'b0;
      stk_wr_addr = IDX_W'(depth_ff);
      rsp_in      = '0;
      if (ctl.finish) begin
         priority if (cmd_ff == CMD_ALLOC && popped_ff) begin
            gen_wr_en             = 1'b1;
            gen_wr_data           = {1'b1, gen_rd_ff[GEN_W-1:0]};
            depth_in              = depth_ff - 1'b1;
            used_in               = used_ff + 1'b1;
            rsp_in.ok             = 1'b1;
            rsp_in.out_index      = IDX_OUT_W'(idx_ff);
            rsp_in.out_generation = gen_rd_ff[GEN_W-1:0];
         end else if (cmd_ff == CMD_ALLOC && !pool_full) begin
            // open the next never-used slot
            gen_wr_en             = 1'b1;
            gen_wr_addr           = IDX_W'(hw_ff);
            gen_wr_data           = {1'b1, GEN_FIRST};
            hw_in                 = hw_ff + 1'b1;
            used_in               = used_ff + 1'b1;
            rsp_in.ok             = 1'b1;
            rsp_in.out_index      = IDX_OUT_W'(hw_ff);
            rsp_in.out_generation = GEN_FIRST;
         end else if (cmd_ff == CMD_FREE && live) begin
            gen_wr_en   = 1'b1;
            gen_wr_data = {1'b0, gen_rd_ff[GEN_W-1:0] + 1'b1};
            if (depth_ff < CNT_W'(SLOTS)) begin
               stk_wr_en = 1'b1;
               depth_in  = depth_ff + 1'b1;
            end
            if (used_ff != '0) begin
               used_in = used_ff - 1'b1;
            end
            rsp_in.ok = 1'b1;
         end else if (cmd_ff == CMD_CHECK) begin
            rsp_in.ok = live;
         end else begin
            rsp_in.ok = 1'b0;
         end
         rsp_in.live_count = CNT_OUT_W'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         hw_ff    <= '0;
         used_ff  <= '0;
      end else begin
         depth_ff <= depth_in;
         hw_ff    <= hw_in;
         used_ff  <= used_in;
      end
   end

   // latched request
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff      <= req.cmd;
         gen_ff      <= req.slot_generation;
         in_range_ff <= in_range_in;
         popped_ff   <= sts.want_pop;
      end
      if (ctl.accept || ctl.pop) begin
         idx_ff <= idx_in;
      end
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_rd_en) begin
         gen_rd_ff <= gen_mem[gen_rd_addr];
      end
      if (gen_wr_en) begin
         gen_mem[gen_wr_addr] <= gen_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_rd_en) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
      if (stk_wr_en) begin
         stk_mem[stk_wr_addr] <= idx_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hdl/ghp_ctrl.sv =====
// Controller: sequences each transaction through accept, a stack pop when an allocate reuses a freed slot, and finish.
`timescale 1ns / 1ps

module ghp_ctrl import ghp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_POP    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = sts.want_pop ? ST_POP : ST_FINISH;
            end
         end
         ST_POP: begin
            ctl.pop  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register can take the result
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctl.finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_finish_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!out_valid_ff || rsp_ready))
      else $error("result loaded while response register still occupied");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> rsp_valid)
      else $error("finished transaction did not raise response valid");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> !req_ready)
      else $error("new transaction taken before the previous one finished");

   a_pop_then_finish: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> (state_ff == ST_FINISH))
      else $error("stack pop not followed by finish");
`endif

endmodule

// ===== hdl/generational_handle_pool.sv =====
// Sequence: the result register loads in the finish step that follows acceptance, or,
// for an allocate that reuses a freed slot, after a stack read, then a generation table
// read; an occupied response register holds the finish step until the downstream side
// takes its transaction. A new transaction is accepted only once the previous one has
// finished, as the controller steps through the dependent reads of the free stack and
// the generation table. Reset: synchronous; clears the counters and controller. The tables
// are not cleared: entries are written before they are read, below the high-water mark.
`timescale 1ns / 1ps

module generational_handle_pool import ghp_pkg::*; #(
   parameter int SLOTS = 256
) (
   input logic        clock,
   input logic        reset,
   ghp_req_if.sink    req_chan,
   ghp_rsp_if.source  rsp_chan
);

   ctl_type ctl;
   sts_type sts;

   ghp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ghp_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts),
      .req   (req_chan.payload),
      .rsp   (rsp_chan.payload)
   );

endmodule
